// File: design/grid_bilinear_interpolator_macros.svh
// Assertion macros for the grid bilinear interpolator.
// Expect a signal named clk, and rst for GBI_ASSERT, in the scope of each use.
// Expand to nothing when SYNTHESIS is defined.
`ifndef GRID_BILINEAR_INTERPOLATOR_MACROS_SVH
`define GRID_BILINEAR_INTERPOLATOR_MACROS_SVH
`ifndef SYNTHESIS
`define GBI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define GBI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define GBI_ASSERT(lbl, prop, msg)
`define GBI_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: design/gbi_pkg.sv
// Shared constants and types for the grid bilinear interpolator.
// No dependencies.
package gbi_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int LOAD_C_W  = 9;
  localparam int LOAD_R_W  = 9;
  localparam int POS_W     = 18;
  localparam int DIM_W     = 10;
  localparam int INTERP_W  = 32;
  localparam int DIM_RESET = 512;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic       is_query;
    logic       wr_ok;
    logic [1:0] wr_bank;
    logic       col_par;
    logic       row_par;
    logic       xint;
    logic       yint;
  } front_t;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

endpackage

// File: design/gbi_if.sv
// Request and result channel interfaces of the grid bilinear interpolator.
// Depends on gbi_pkg.
interface gbi_req_if import gbi_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [LOAD_C_W-1:0]        load_col;
  logic [LOAD_R_W-1:0]        load_row;
  logic signed [SAMPLE_W-1:0] load_sample;
  logic [POS_W-1:0]           pos_x;
  logic [POS_W-1:0]           pos_y;

  modport source (output valid, req_type, load_col, load_row, load_sample, pos_x, pos_y,
                  input ready);
  modport sink (input valid, req_type, load_col, load_row, load_sample, pos_x, pos_y,
                output ready);
endinterface

interface gbi_res_if import gbi_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [INTERP_W-1:0] interp_value;
  logic signed [SAMPLE_W-1:0] rounded_value;

  modport source (output valid, interp_value, rounded_value, input ready);
  modport sink (input valid, interp_value, rounded_value, output ready);
endinterface

// File: design/grid_bilinear_interpolator.sv
// Grid bilinear interpolator, top level.
// Depends on gbi_pkg, gbi_if, gbi_ram, gbi_front and gbi_blend.
//
// Usage:
//   req carries load and query requests; res carries one result per query,
//   loads give none. A load writes one cell of the grid. A query clamps its
//   position to the grid in use and returns the blend of four neighbors
//   with 16 fraction bits, plus a rounded integer.
//   wr_en / wr_index / wr_data set grid_width (index 0) and grid_height
//   (index 1); write them only while the pipeline is empty.
//   The grid is held in four banks split by column and row parity, so all
//   four neighbors are read in the same cycle.
//   Throughput: one request per cycle while res is not stalled. Requests
//   pass five register stages: decode, bank read, products, sum, output.
//   Reset clears the pipeline and sets both dimensions to 512, capped at
//   the grid maximum. Grid contents are undefined until loaded; there is
//   no clearing pass.
//   When res stalls, stages keep their data and bubbles close up; req.ready
//   drops only when all five stages hold requests.
`include "grid_bilinear_interpolator_macros.svh"
module grid_bilinear_interpolator import gbi_pkg::*; #(
  parameter int GRID_W_MAX = 512,
  parameter int GRID_H_MAX = 512,
  parameter int FRAC_BITS  = 8
) (
  input  logic             clk,
  input  logic             rst,
  gbi_req_if.sink          req,
  gbi_res_if.source        res,
  input  logic             wr_en,
  input  logic             wr_index,
  input  logic [DIM_W-1:0] wr_data
);

  localparam int CW    = ($clog2(GRID_W_MAX) < 2) ? 2 : $clog2(GRID_W_MAX);
  localparam int RW    = ($clog2(GRID_H_MAX) < 2) ? 2 : $clog2(GRID_H_MAX);
  localparam int BA_W  = CW + RW - 2;
  localparam int BANK_DEPTH = 1 << BA_W;
  localparam int DEF_W = (DIM_RESET > GRID_W_MAX) ? GRID_W_MAX : DIM_RESET;
  localparam int DEF_H = (DIM_RESET > GRID_H_MAX) ? GRID_H_MAX : DIM_RESET;

  logic [CW-1:0]              wlast;
  logic [RW-1:0]              hlast;
  logic [CW-1:0]              wlast_next;
  logic [RW-1:0]              hlast_next;

  logic                       v1;
  logic                       v2;
  logic                       v3;
  logic                       v4;
  logic                       v5;
  logic                       en1;
  stage_en_t                  en;

  front_t                     ctl1;
  logic [BA_W-1:0]            addr [4];
  logic signed [SAMPLE_W-1:0] wdata;
  logic [FRAC_BITS-1:0]       fx;
  logic [FRAC_BITS-1:0]       fy;
  logic [3:0]                 bank_we;
  logic [3:0]                 bank_re;
  logic signed [SAMPLE_W-1:0] rd [4];

  // configuration
  always_comb begin
    if (wr_data == '0) begin
      wlast_next = '0;
      hlast_next = '0;
    end else begin
      wlast_next = (32'(wr_data) > 32'(GRID_W_MAX)) ? CW'(GRID_W_MAX - 1)
                                                     : CW'(wr_data - DIM_W'(1));
      hlast_next = (32'(wr_data) > 32'(GRID_H_MAX)) ? RW'(GRID_H_MAX - 1)
                                                     : RW'(wr_data - DIM_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wlast <= CW'(DEF_W - 1);
      hlast <= RW'(DEF_H - 1);
    end else if (wr_en) begin
      case (wr_index)
        REG_GRID_WIDTH:  wlast <= wlast_next;
        REG_GRID_HEIGHT: hlast <= hlast_next;
        default: ;
      endcase
    end
  end

  // stage advance
  always_comb begin
    en.s5 = !v5 || res.ready;
    en.s4 = !v4 || en.s5;
    en.s3 = !v3 || en.s4;
    en.s2 = !v2 || en.s3;
    en1   = !v1 || en.s2;
  end

  assign req.ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= req.valid;
      end
      if (en.s2) begin
        v2 <= v1 && ctl1.is_query;
      end
      if (en.s3) begin
        v3 <= v2;
      end
      if (en.s4) begin
        v4 <= v3;
      end
      if (en.s5) begin
        v5 <= v4;
      end
    end
  end

  gbi_front #(
    .GRID_W_MAX (GRID_W_MAX),
    .GRID_H_MAX (GRID_H_MAX),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .en          (en1),
    .req_type    (req.req_type),
    .load_col    (req.load_col),
    .load_row    (req.load_row),
    .load_sample (req.load_sample),
    .pos_x       (req.pos_x),
    .pos_y       (req.pos_y),
    .wlast       (wlast),
    .hlast       (hlast),
    .ctl         (ctl1),
    .addr        (addr),
    .wdata       (wdata),
    .fx          (fx),
    .fy          (fy)
  );

  genvar b;
  generate
    for (b = 0; b < 4; b++) begin : g_bank
      assign bank_we[b] = v1 && !ctl1.is_query && ctl1.wr_ok &&
                          (ctl1.wr_bank == 2'(b)) && en.s2;
      assign bank_re[b] = v1 && ctl1.is_query && en.s2;

      gbi_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (BANK_DEPTH)
      ) u_ram (
        .clk   (clk),
        .we    (bank_we[b]),
        .waddr (addr[b]),
        .wdata (wdata),
        .re    (bank_re[b]),
        .raddr (addr[b]),
        .rdata (rd[b])
      );
    end
  endgenerate

  gbi_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk           (clk),
    .en            (en),
    .ctl           (ctl1),
    .fx            (fx),
    .fy            (fy),
    .rd            (rd),
    .interp_value  (res.interp_value),
    .rounded_value (res.rounded_value)
  );

  assign res.valid = v5;

  `GBI_ASSERT_ALWAYS(a_one_bank_write, $onehot0(bank_we), "more than one bank written")
  `GBI_ASSERT(a_no_rw_mix, !((|bank_we) && (|bank_re)), "bank read and write mixed")
  `GBI_ASSERT(a_ready_full, !req.ready |-> (v1 && v2 && v3 && v4 && v5 && !res.ready), "request stalled with a free stage")
  `GBI_ASSERT(a_query_moves, (v1 && en.s2 && ctl1.is_query) |=> v2, "query lost after bank read")
  `GBI_ASSERT(a_dim_range, (32'(wlast) < 32'(GRID_W_MAX)) && (32'(hlast) < 32'(GRID_H_MAX)), "grid dimension out of range")

endmodule

// File: design/gbi_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module gbi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/gbi_front.sv
// Request decode: clamp, edge detection, fractions and bank addresses.
// Depends on gbi_pkg; registers its outputs as pipeline stage one.
module gbi_front import gbi_pkg::*; #(
  parameter int GRID_W_MAX = 512,
  parameter int GRID_H_MAX = 512,
  parameter int FRAC_BITS  = 8,
  localparam int CW   = ($clog2(GRID_W_MAX) < 2) ? 2 : $clog2(GRID_W_MAX),
  localparam int RW   = ($clog2(GRID_H_MAX) < 2) ? 2 : $clog2(GRID_H_MAX),
  localparam int BA_W = CW + RW - 2
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic                       req_type,
  input  logic [LOAD_C_W-1:0]        load_col,
  input  logic [LOAD_R_W-1:0]        load_row,
  input  logic signed [SAMPLE_W-1:0] load_sample,
  input  logic [POS_W-1:0]           pos_x,
  input  logic [POS_W-1:0]           pos_y,
  input  logic [CW-1:0]              wlast,
  input  logic [RW-1:0]              hlast,
  output front_t                     ctl,
  output logic [BA_W-1:0]            addr [4],
  output logic signed [SAMPLE_W-1:0] wdata,
  output logic [FRAC_BITS-1:0]       fx,
  output logic [FRAC_BITS-1:0]       fy
);

  localparam int IXW = POS_W - FRAC_BITS;

  logic [IXW-1:0]       ix;
  logic [IXW-1:0]       iy;
  logic                 xint;
  logic                 yint;
  logic [CW-1:0]        i1;
  logic [CW-1:0]        i2;
  logic [RW-1:0]        j1;
  logic [RW-1:0]        j2;
  logic [CW-1:0]        csel [2];
  logic [RW-1:0]        rsel [2];
  logic [CW-1:0]        lc;
  logic [RW-1:0]        lr;
  logic                 lok;
  logic                 is_query;
  front_t               ctl_next;
  logic [BA_W-1:0]      addr_next [4];
  logic [FRAC_BITS-1:0] fx_next;
  logic [FRAC_BITS-1:0] fy_next;

  always_comb begin
    ix   = pos_x[POS_W-1:FRAC_BITS];
    iy   = pos_y[POS_W-1:FRAC_BITS];
    xint = 32'(ix) < 32'(wlast);
    yint = 32'(iy) < 32'(hlast);
    i1   = xint ? CW'(ix) : wlast;
    j1   = yint ? RW'(iy) : hlast;
    i2   = i1 + CW'(1);
    j2   = j1 + RW'(1);
    for (int b = 0; b < 2; b++) begin
      csel[b] = (i1[0] == 1'(b)) ? i1 : i2;
      rsel[b] = (j1[0] == 1'(b)) ? j1 : j2;
    end

    lc  = CW'(load_col);
    lr  = RW'(load_row);
    lok = (32'(load_col) < 32'(GRID_W_MAX)) && (32'(load_row) < 32'(GRID_H_MAX));

    is_query = (req_type == REQ_QUERY);
    for (int b = 0; b < 4; b++) begin
      if (is_query) begin
        addr_next[b] = {rsel[b / 2][RW-1:1], csel[b % 2][CW-1:1]};
      end else begin
        addr_next[b] = {lr[RW-1:1], lc[CW-1:1]};
      end
    end

    ctl_next.is_query = is_query;
    ctl_next.wr_ok    = lok;
    ctl_next.wr_bank  = {lr[0], lc[0]};
    ctl_next.col_par  = i1[0];
    ctl_next.row_par  = j1[0];
    ctl_next.xint     = xint;
    ctl_next.yint     = yint;

    fx_next = xint ? pos_x[FRAC_BITS-1:0] : '0;
    fy_next = yint ? pos_y[FRAC_BITS-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl   <= ctl_next;
      addr  <= addr_next;
      wdata <= load_sample;
      fx    <= fx_next;
      fy    <= fy_next;
    end
  end

endmodule

// File: design/gbi_blend.sv
// Bilinear blend: weights, products, sum and output rounding.
// Depends on gbi_pkg; stages two to five of the pipeline.
module gbi_blend import gbi_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                       clk,
  input  stage_en_t                  en,
  input  front_t                     ctl,
  input  logic [FRAC_BITS-1:0]       fx,
  input  logic [FRAC_BITS-1:0]       fy,
  input  logic signed [SAMPLE_W-1:0] rd [4],
  output logic signed [INTERP_W-1:0] interp_value,
  output logic signed [SAMPLE_W-1:0] rounded_value
);

  localparam int SH = 2 * FRAC_BITS;
  localparam int WW = SH + 1;
  localparam int PW = SAMPLE_W + WW + 1;
  localparam int AW = PW + 2;
  localparam logic [FRAC_BITS:0] SCALE   = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam logic [SH+4:0]      RND_THR = (SH + 5)'(9) << SH;

  logic [FRAC_BITS:0]         sx;
  logic [FRAC_BITS:0]         sy;
  logic [WW-1:0]              wt_next [4];
  logic [WW-1:0]              wt [4];
  front_t                     ctl2;
  logic signed [SAMPLE_W-1:0] h [4];
  logic signed [WW:0]         ws [4];
  logic signed [PW-1:0]       prod_next [4];
  logic signed [PW-1:0]       prod [4];
  logic signed [AW-1:0]       acc;
  logic [SH-1:0]              frac;
  logic [SH+4:0]              f20;
  logic                       up;
  logic signed [INTERP_W-1:0] interp_next;
  logic signed [SAMPLE_W-1:0] rnd_next;

  // weights in order h11, h21, h12, h22
  always_comb begin
    sx = SCALE - {1'b0, fx};
    sy = SCALE - {1'b0, fy};
    wt_next[0] = WW'({{FRAC_BITS{1'b0}}, sx} * {{FRAC_BITS{1'b0}}, sy});
    wt_next[1] = WW'({{(FRAC_BITS+1){1'b0}}, fx} * {{FRAC_BITS{1'b0}}, sy});
    wt_next[2] = WW'({{FRAC_BITS{1'b0}}, sx} * {{(FRAC_BITS+1){1'b0}}, fy});
    wt_next[3] = WW'({{(FRAC_BITS+1){1'b0}}, fx} * {{(FRAC_BITS+1){1'b0}}, fy});
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      wt   <= wt_next;
      ctl2 <= ctl;
    end
  end

  // route bank data to neighbors; drop cells past the edge
  always_comb begin
    h[0] = rd[{ctl2.row_par, ctl2.col_par}];
    h[1] = ctl2.xint ? rd[{ctl2.row_par, ~ctl2.col_par}] : '0;
    h[2] = ctl2.yint ? rd[{~ctl2.row_par, ctl2.col_par}] : '0;
    h[3] = (ctl2.xint && ctl2.yint) ? rd[{~ctl2.row_par, ~ctl2.col_par}] : '0;
    for (int k = 0; k < 4; k++) begin
      ws[k]        = $signed({1'b0, wt[k]});
      prod_next[k] = h[k] * ws[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      prod <= prod_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      acc <= AW'(prod[0]) + AW'(prod[1]) + AW'(prod[2]) + AW'(prod[3]);
    end
  end

  generate
    if (SH >= 16) begin : g_shr
      assign interp_next = acc[SH+15:SH-16];
    end else begin : g_shl
      assign interp_next = {acc[SH+15:0], {(16-SH){1'b0}}};
    end
  endgenerate

  always_comb begin
    frac     = acc[SH-1:0];
    f20      = {1'b0, frac, 4'b0} + {3'b0, frac, 2'b0};
    up       = f20 > RND_THR;
    rnd_next = acc[SH+15:SH] + {{(SAMPLE_W-1){1'b0}}, up};
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      interp_value  <= interp_next;
      rounded_value <= rnd_next;
    end
  end

endmodule

// File: tb/gbi_checker.sv
// Checker for the grid bilinear interpolator: mirrors grid loads and dimension
// writes, predicts each query's blend and compares it with the result channel.
// Depends on gbi_pkg and gbi_if.
`timescale 1ns / 100ps
module gbi_checker import gbi_pkg::*; #(
  parameter int GRID_W_MAX = 512,
  parameter int GRID_H_MAX = 512,
  parameter int FRAC_BITS  = 8
) (
  input  logic             clk,
  input  logic             rst,
  gbi_req_if               req,
  gbi_res_if               res,
  input  logic             wr_en,
  input  logic             wr_index,
  input  logic [DIM_W-1:0] wr_data,
  input  logic             wrap_up,
  output int               error_count
);

  localparam int PROD_BITS = 2 * FRAC_BITS;

  typedef struct packed {
    logic signed [INTERP_W-1:0] value;
    logic signed [SAMPLE_W-1:0] rounded;
  } blend_t;

  logic signed [SAMPLE_W-1:0] heights [GRID_W_MAX*GRID_H_MAX];
  logic [DIM_W-1:0]           cols_reg;
  logic [DIM_W-1:0]           rows_reg;
  blend_t                     pending_blends [$];
  blend_t                     want;
  bit                         leftover_seen;

  initial error_count = 0;

  task automatic report(string what);
    error_count++;
    if (error_count <= 40) $display("%0t ns: %s", $time, what);
  endtask

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic longint signed height_at(int unsigned c, int unsigned r);
    return longint'(heights[r*GRID_W_MAX + c]);
  endfunction

  function automatic blend_t blend_at(logic [POS_W-1:0] px, logic [POS_W-1:0] py);
    int unsigned       w, h, i1, j1, i2, j2;
    longint signed     s, fx, fy, acc, whole;
    longint unsigned   frac, unit;
    blend_t            b;
    w  = clamp_dim(cols_reg, GRID_W_MAX);
    h  = clamp_dim(rows_reg, GRID_H_MAX);
    s  = longint'(1) << FRAC_BITS;
    i1 = px >> FRAC_BITS;
    j1 = py >> FRAC_BITS;
    if (i1 > w - 1) i1 = w - 1;
    if (j1 > h - 1) j1 = h - 1;
    i2 = i1;
    j2 = j1;
    fx = 0;
    fy = 0;
    if (i1 < w - 1) begin
      i2 = i1 + 1;
      fx = px & (s - 1);
    end
    if (j1 < h - 1) begin
      j2 = j1 + 1;
      fy = py & (s - 1);
    end
    acc = height_at(i1, j1) * (s - fx) * (s - fy)
        + height_at(i2, j1) * fx * (s - fy)
        + height_at(i1, j2) * (s - fx) * fy
        + height_at(i2, j2) * fx * fy;
    if (PROD_BITS >= 16) b.value = INTERP_W'(acc >>> (PROD_BITS - 16));
    else b.value = INTERP_W'(acc <<< (16 - PROD_BITS));
    unit  = longint'(1) << PROD_BITS;
    whole = acc >>> PROD_BITS;
    frac  = acc & (unit - 1);
    if (20 * frac > 9 * unit) whole++;
    b.rounded = SAMPLE_W'(whole);
    return b;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cols_reg = DIM_RESET;
      rows_reg = DIM_RESET;
    end else begin
      if (wr_en) begin
        if (wr_index == REG_GRID_WIDTH) cols_reg = wr_data;
        else rows_reg = wr_data;
      end
      if (res.valid && res.ready) begin
        if (pending_blends.size() == 0) begin
          report("result with no query outstanding");
        end else begin
          want = pending_blends.pop_front();
          if (res.interp_value !== want.value)
            report($sformatf("interp_value got %0d want %0d", res.interp_value, want.value));
          if (res.rounded_value !== want.rounded)
            report($sformatf("rounded_value got %0d want %0d",
                             res.rounded_value, want.rounded));
        end
      end
      if (req.valid && req.ready) begin
        if (req.req_type == REQ_QUERY)
          pending_blends.push_back(blend_at(req.pos_x, req.pos_y));
        else if (req.load_col < GRID_W_MAX && req.load_row < GRID_H_MAX)
          heights[req.load_row*GRID_W_MAX + req.load_col] = req.load_sample;
      end
      if (wrap_up && !leftover_seen && pending_blends.size() != 0) begin
        leftover_seen = 1;
        report($sformatf("%0d queries never answered", pending_blends.size()));
      end
    end
  end

endmodule

// File: tb/tb_top.sv
// Top of the grid bilinear interpolator testbench: clock, reset, dimension
// writes, load and query requests, result back-pressure and the verdict.
// Depends on gbi_pkg, gbi_if, grid_bilinear_interpolator and gbi_checker.
`timescale 1ns / 100ps
module tb_top;
  import gbi_pkg::*;

  localparam int GRID_SPAN   = 512;
  localparam int POS_FRAC    = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 150;

  logic             clk;
  logic             rst;
  logic             wr_en;
  logic             wr_index;
  logic [DIM_W-1:0] wr_data;
  logic             wrap_up;
  int               error_count;

  int unsigned queries_sent;
  int unsigned results_taken;
  int unsigned items_sent;
  int unsigned idle_cycles;
  int unsigned cur_w;
  int unsigned cur_h;
  int unsigned anchor_x;
  int unsigned anchor_y;
  bit          calm;
  bit          loaded [GRID_SPAN*GRID_SPAN];

  gbi_req_if req_ch ();
  gbi_res_if res_ch ();

  grid_bilinear_interpolator u_top (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .res      (res_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  gbi_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .res         (res_ch),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .wrap_up     (wrap_up),
    .error_count (error_count)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned eff_dim(int unsigned v);
    if (v == 0) return 1;
    if (v > GRID_SPAN) return GRID_SPAN;
    return v;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 4))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_request(logic kind, logic [LOAD_C_W-1:0] col, logic [LOAD_R_W-1:0] row,
                              logic signed [SAMPLE_W-1:0] smp, logic [POS_W-1:0] px,
                              logic [POS_W-1:0] py);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      req_ch.valid = 0;
      repeat (gap) @(negedge clk);
    end
    req_ch.req_type    = kind;
    req_ch.load_col    = col;
    req_ch.load_row    = row;
    req_ch.load_sample = smp;
    req_ch.pos_x       = px;
    req_ch.pos_y       = py;
    req_ch.valid       = 1;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
    if (kind == REQ_QUERY) queries_sent++;
    @(negedge clk);
  endtask

  task automatic load_cell(int unsigned col, int unsigned row, logic signed [SAMPLE_W-1:0] v);
    loaded[row*GRID_SPAN + col] = 1;
    send_request(REQ_LOAD, LOAD_C_W'(col), LOAD_R_W'(row), v, POS_W'($urandom),
                 POS_W'($urandom));
  endtask

  // fill any unwritten neighbor first so the block never reads an empty cell
  task automatic query_at(logic [POS_W-1:0] px, logic [POS_W-1:0] py);
    int unsigned cols [2];
    int unsigned rows [2];
    cols[0] = px >> POS_FRAC;
    rows[0] = py >> POS_FRAC;
    if (cols[0] > cur_w - 1) cols[0] = cur_w - 1;
    if (rows[0] > cur_h - 1) rows[0] = cur_h - 1;
    cols[1] = (cols[0] < cur_w - 1) ? cols[0] + 1 : cols[0];
    rows[1] = (rows[0] < cur_h - 1) ? rows[0] + 1 : rows[0];
    foreach (cols[a])
      foreach (rows[b])
        if (!loaded[rows[b]*GRID_SPAN + cols[a]]) load_cell(cols[a], rows[b], pick_sample());
    send_request(REQ_QUERY, LOAD_C_W'($urandom), LOAD_R_W'($urandom), SAMPLE_W'($urandom),
                 px, py);
  endtask

  task automatic set_dims(int unsigned w, int unsigned h);
    req_ch.valid = 0;
    while (results_taken != queries_sent) @(negedge clk);
    repeat (8) @(negedge clk);
    wr_en    = 1;
    wr_index = REG_GRID_WIDTH;
    wr_data  = DIM_W'(w);
    @(negedge clk);
    wr_index = REG_GRID_HEIGHT;
    wr_data  = DIM_W'(h);
    @(negedge clk);
    wr_en = 0;
    cur_w = eff_dim(w);
    cur_h = eff_dim(h);
    anchor_x = $urandom_range(0, cur_w - 1);
    anchor_y = $urandom_range(0, cur_h - 1);
  endtask

  task automatic random_phase(int unsigned count);
    int unsigned stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 29) == 0) calm = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 19) == 0) begin
        anchor_x = $urandom_range(0, cur_w - 1);
        anchor_y = $urandom_range(0, cur_h - 1);
      end
      case ($urandom_range(0, 9))
        0, 1: load_cell($urandom_range(0, GRID_SPAN - 1), $urandom_range(0, GRID_SPAN - 1),
                        pick_sample());
        2: query_at(POS_W'($urandom), POS_W'($urandom));
        3: query_at(POS_W'(((cur_w - 1 + $urandom_range(0, 1)) << POS_FRAC)
                           | $urandom_range(0, 255)),
                    POS_W'(((cur_h - 1 + $urandom_range(0, 1)) << POS_FRAC)
                           | $urandom_range(0, 255)));
        default: query_at(POS_W'(((anchor_x + $urandom_range(0, 3)) << POS_FRAC)
                                 | $urandom_range(0, 255)),
                          POS_W'(((anchor_y + $urandom_range(0, 3)) << POS_FRAC)
                                 | $urandom_range(0, 255)));
      endcase
    end
  endtask

  initial begin : drain_results
    int unsigned hold;
    res_ch.ready = 0;
    wait (!rst);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 6);
      if (hold != 0) begin
        res_ch.ready = 0;
        repeat (hold) @(negedge clk);
      end
      res_ch.ready = 1;
      do @(posedge clk); while (!res_ch.valid);
      results_taken++;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL grid_bilinear_interpolator");
      $finish;
    end
  end

  initial begin
    rst                = 1;
    req_ch.valid       = 0;
    req_ch.req_type    = REQ_LOAD;
    req_ch.load_col    = '0;
    req_ch.load_row    = '0;
    req_ch.load_sample = '0;
    req_ch.pos_x       = '0;
    req_ch.pos_y       = '0;
    wr_en              = 0;
    wr_index           = REG_GRID_WIDTH;
    wr_data            = '0;
    wrap_up            = 0;
    calm               = 0;
    cur_w              = GRID_SPAN;
    cur_h              = GRID_SPAN;
    anchor_x           = 0;
    anchor_y           = 0;
    repeat (12) @(negedge clk);
    rst = 0;

    // extreme samples, exact cell, midpoint and skewed blends
    load_cell(0, 0, 16'sh8000);
    load_cell(1, 0, 16'sh7FFF);
    load_cell(0, 1, 16'sh7FFF);
    load_cell(1, 1, 16'sh8000);
    query_at(18'h00000, 18'h00000);
    query_at(18'h00080, 18'h00080);
    query_at(18'h000FF, 18'h00001);
    // rounding threshold on both sides of 0.45, positive and negative
    load_cell(10, 10, 0);
    load_cell(11, 10, 1);
    load_cell(10, 11, 0);
    load_cell(11, 11, 1);
    query_at({10'd10, 8'd115}, {10'd10, 8'd0});
    query_at({10'd10, 8'd116}, {10'd10, 8'd0});
    load_cell(20, 20, -1);
    load_cell(21, 20, 0);
    load_cell(20, 21, -1);
    load_cell(21, 21, 0);
    query_at({10'd20, 8'd116}, {10'd20, 8'd0});
    query_at({10'd20, 8'd115}, {10'd20, 8'd0});
    // far corner, last column, last row, position beyond the grid
    query_at(18'h3FFFF, 18'h3FFFF);
    query_at({10'd511, 8'h40}, {10'd3, 8'h80});
    query_at({10'd5, 8'hC0}, {10'd700, 8'h33});

    set_dims(1, 1);       random_phase(PHASE_ITEMS);
    set_dims(0, 0);       random_phase(PHASE_ITEMS);
    set_dims(1023, 1023); random_phase(PHASE_ITEMS);
    set_dims(2, 2);       random_phase(PHASE_ITEMS);
    set_dims(512, 1);     random_phase(PHASE_ITEMS);
    set_dims(1, 512);     random_phase(PHASE_ITEMS);
    set_dims(3, 7);       random_phase(PHASE_ITEMS);
    set_dims($urandom_range(1, 40), $urandom_range(1, 40)); random_phase(PHASE_ITEMS);
    set_dims($urandom_range(1, 40), $urandom_range(1, 40)); random_phase(PHASE_ITEMS);
    set_dims(511, 2);     random_phase(PHASE_ITEMS);
    set_dims(512, 512);   random_phase(PHASE_ITEMS);

    req_ch.valid = 0;
    while (results_taken != queries_sent) @(negedge clk);
    repeat (10) @(negedge clk);
    wrap_up = 1;
    @(negedge clk);
    if (error_count == 0)
      $display("PASS grid_bilinear_interpolator");
    else
      $display("FAIL grid_bilinear_interpolator");
    $finish;
  end

endmodule
